// ===== hdl/hbkt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbkt_pkg
// Shared types, usage codes and key translation for the boot keyboard
// translator.
// ----------------------------------------------------------------------------
package hbkt_pkg;

  localparam int unsigned KeySlots  = 6;
  localparam int unsigned UsageW    = 8;
  localparam int unsigned SlotIdxW  = $clog2(KeySlots);
  localparam int unsigned ScanW     = 5;
  localparam int unsigned CharW     = 7;
  localparam int unsigned ModsW     = 4;
  localparam int unsigned InDataW   = UsageW * (KeySlots + 1);
  localparam int unsigned OutFieldW = ScanW + CharW + 1 + ModsW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [SlotIdxW-1:0] LastSlot = SlotIdxW'(KeySlots - 1);

  localparam logic [UsageW-1:0] UsageRollover = 8'h01;
  localparam logic [UsageW-1:0] UsageCaps     = 8'h39;
  localparam logic [UsageW-1:0] UsageEnter    = 8'h28;
  localparam logic [UsageW-1:0] UsageEscape   = 8'h29;
  localparam logic [UsageW-1:0] UsageBksp     = 8'h2A;
  localparam logic [UsageW-1:0] UsageTab      = 8'h2B;
  localparam logic [UsageW-1:0] UsageDelete   = 8'h4C;
  localparam logic [UsageW-1:0] UsageRight    = 8'h4F;
  localparam logic [UsageW-1:0] UsageLeft     = 8'h50;
  localparam logic [UsageW-1:0] UsageDown     = 8'h51;
  localparam logic [UsageW-1:0] UsageUp       = 8'h52;
  localparam logic [UsageW-1:0] UsageLetterA  = 8'h04;
  localparam logic [UsageW-1:0] UsageLetterZ  = 8'h1D;

  localparam logic [ScanW-1:0] ScanUp     = 5'd1;
  localparam logic [ScanW-1:0] ScanDown   = 5'd2;
  localparam logic [ScanW-1:0] ScanRight  = 5'd3;
  localparam logic [ScanW-1:0] ScanLeft   = 5'd4;
  localparam logic [ScanW-1:0] ScanDelete = 5'd8;
  localparam logic [ScanW-1:0] ScanEscape = 5'd23;

  localparam logic [7:0] ModShift = 8'h22;
  localparam logic [7:0] ModCtrl  = 8'h11;
  localparam logic [7:0] ModAlt   = 8'h44;
  localparam logic [7:0] ModGui   = 8'h88;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MASK,
    ST_SCAN
  } hbkt_state_e;

  typedef struct packed {
    logic                load;
    logic                mask_en;
    logic                step;
    logic                commit;
    logic [SlotIdxW-1:0] slot_idx;
  } hbkt_cmd_t;

  typedef struct packed {
    logic rollover;
    logic slot_emit;
    logic out_free;
  } hbkt_sts_t;

  typedef struct packed {
    logic [ScanW-1:0] scan;
    logic [CharW-1:0] chr;
  } hbkt_key_t;

  function automatic logic [CharW-1:0] plain_char(input logic [UsageW-1:0] u);
    logic [CharW-1:0] c;
    c = '0;
    if (u >= UsageLetterA && u <= UsageLetterZ) begin
      c = CharW'(u + 8'h5D);
    end else begin
      case (u)
        8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22,
        8'h23, 8'h24, 8'h25, 8'h26: c = CharW'(u + 8'h13);
        8'h27: c = 7'h30;
        8'h2C: c = 7'h20;
        8'h2D: c = 7'h2D;
        8'h2E: c = 7'h3D;
        8'h2F: c = 7'h5B;
        8'h30: c = 7'h5D;
        8'h31: c = 7'h5C;
        8'h33: c = 7'h3B;
        8'h34: c = 7'h27;
        8'h35: c = 7'h60;
        8'h36: c = 7'h2C;
        8'h37: c = 7'h2E;
        8'h38: c = 7'h2F;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [CharW-1:0] shift_char(input logic [UsageW-1:0] u);
    logic [CharW-1:0] c;
    c = '0;
    if (u >= UsageLetterA && u <= UsageLetterZ) begin
      c = CharW'(u + 8'h3D);
    end else begin
      case (u)
        8'h1E: c = 7'h21;
        8'h1F: c = 7'h40;
        8'h20: c = 7'h23;
        8'h21: c = 7'h24;
        8'h22: c = 7'h25;
        8'h23: c = 7'h5E;
        8'h24: c = 7'h26;
        8'h25: c = 7'h2A;
        8'h26: c = 7'h28;
        8'h27: c = 7'h29;
        8'h2C: c = 7'h20;
        8'h2D: c = 7'h5F;
        8'h2E: c = 7'h2B;
        8'h2F: c = 7'h7B;
        8'h30: c = 7'h7D;
        8'h31: c = 7'h7C;
        8'h33: c = 7'h3A;
        8'h34: c = 7'h22;
        8'h35: c = 7'h7E;
        8'h36: c = 7'h3C;
        8'h37: c = 7'h3E;
        8'h38: c = 7'h3F;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  function automatic hbkt_key_t translate(input logic [UsageW-1:0] u,
                                          input logic shift, input logic caps);
    hbkt_key_t k;
    logic      up;
    k.scan = '0;
    k.chr  = '0;
    up     = shift ^ (caps && u >= UsageLetterA && u <= UsageLetterZ);
    unique case (u)
      UsageEnter:  k.chr  = 7'd13;
      UsageBksp:   k.chr  = 7'd8;
      UsageTab:    k.chr  = 7'd9;
      UsageEscape: k.scan = ScanEscape;
      UsageDelete: k.scan = ScanDelete;
      UsageRight:  k.scan = ScanRight;
      UsageLeft:   k.scan = ScanLeft;
      UsageDown:   k.scan = ScanDown;
      UsageUp:     k.scan = ScanUp;
      default:     k.chr  = up ? shift_char(u) : plain_char(u);
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/hbkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbkt_ctrl
// Sequencer: takes a report, builds the press mask, then walks the slots; a rollover report returns it to idle instead.
// ----------------------------------------------------------------------------
module hbkt_ctrl import hbkt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hbkt_sts_t sts_i,
  output hbkt_cmd_t cmd_o
);

  hbkt_state_e         state_q, state_d;
  logic [SlotIdxW-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.slot_idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MASK;
        end
      end
      ST_MASK: begin
        idx_d = '0;
        if (sts_i.rollover) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.mask_en = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.slot_emit || sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (idx_q == LastSlot) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/hbkt_dp.sv =====
// ----------------------------------------------------------------------------
// hbkt_dp
// Report registers, previous-report store, caps flag, press mask and the
// output register.
// ----------------------------------------------------------------------------
module hbkt_dp import hbkt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  in_data_i,
  input  hbkt_cmd_t           cmd_i,
  output hbkt_sts_t           sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o
);

  logic [7:0]        mods_q;
  logic [UsageW-1:0] keys_q  [KeySlots];
  logic [UsageW-1:0] prior_q [KeySlots];
  logic              caps_q, caps_d;
  logic [KeySlots-1:0] mask_q, mask_d, fresh;
  logic              out_valid_q, out_valid_d;
  logic [ScanW-1:0]  out_scan_q;
  logic [CharW-1:0]  out_chr_q;
  logic              out_ctrl_q;
  logic [ModsW-1:0]  out_mods_q;
  logic              out_last_q;
  logic [UsageW-1:0] cur_key;
  hbkt_key_t         cur_map, probe;
  logic [KeySlots-1:0] later;
  logic              shift, ctrl;
  logic [ModsW-1:0]  mods;

  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      fresh[i] = keys_q[i] != '0;
      for (int j = 0; j < KeySlots; j++) begin
        if (prior_q[j] == keys_q[i]) fresh[i] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      probe     = translate(keys_q[i], 1'b0, 1'b0);
      mask_d[i] = fresh[i] && keys_q[i] != UsageCaps &&
                  (probe.scan != '0 || probe.chr != '0);
    end
  end

  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      later[i] = mask_q[i] && (SlotIdxW'(i) > cmd_i.slot_idx);
    end
  end

  assign shift   = |(mods_q & ModShift);
  assign ctrl    = |(mods_q & ModCtrl);
  assign mods    = {|(mods_q & ModGui), |(mods_q & ModAlt), ctrl, shift};
  assign cur_key = keys_q[cmd_i.slot_idx];
  assign cur_map = translate(cur_key, shift, caps_q);

  assign caps_d = caps_q ^ (cmd_i.step && fresh[cmd_i.slot_idx] &&
                            cur_key == UsageCaps);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.step && mask_q[cmd_i.slot_idx]) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KeySlots; i++) prior_q[i] <= '0;
    end else begin
      caps_q      <= caps_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        for (int i = 0; i < KeySlots; i++) prior_q[i] <= keys_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mods_q <= in_data_i[7:0];
      for (int i = 0; i < KeySlots; i++) begin
        keys_q[i] <= in_data_i[UsageW*(i+1) +: UsageW];
      end
    end
    if (cmd_i.mask_en) mask_q <= mask_d;
    if (cmd_i.step && mask_q[cmd_i.slot_idx]) begin
      out_scan_q <= cur_map.scan;
      out_chr_q  <= cur_map.chr;
      out_ctrl_q <= ctrl;
      out_mods_q <= mods;
      out_last_q <= ~|later;
    end
  end

  assign sts_o.rollover  = keys_q[0] == UsageRollover;
  assign sts_o.slot_emit = mask_q[cmd_i.slot_idx];
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = OutDataW'({out_mods_q, out_ctrl_q, out_chr_q, out_scan_q});

endmodule

// ===== hdl/hid_boot_keyboard_translator_core.sv =====
// ----------------------------------------------------------------------------
// hid_boot_keyboard_translator_core
// Turns HID boot-keyboard reports into key-press events.
// ----------------------------------------------------------------------------
// A report is taken in the idle state; the block then builds the mask of
// fresh presses and walks the six usage slots in order. Each fresh press
// that maps to a character or a navigation scan code leaves as one
// transaction on the master side, with tlast on the final one of the
// report; a stalled output holds the slot walk. Rollover reports are
// dropped from the mask state, back to idle, and leave the key history and
// caps state untouched. The slave side is ready whenever no report is in
// work, even while a result still waits on the master side.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_translator_core import hbkt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // modifier_bits, keycode_0 .. keycode_5
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scan_code, char_code, ctrl_held, held_mods, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // last_event
  output logic                m_axis_tlast
);

  hbkt_cmd_t cmd;
  hbkt_sts_t sts;

  hbkt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hbkt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // a result is only written into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step && sts.slot_emit |-> sts.out_free)
    else $error("output register overwritten");

  // no new report is taken while slots are being walked
  a_busy_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !s_axis_tready)
    else $error("report accepted during slot walk");

  // a rollover report returns the block to idle without a walk
  a_rollover_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[15:8] == UsageRollover
    |=> ##1 s_axis_tready)
    else $error("rollover report not dropped");

endmodule

// ===== bench/keystroke_checker.sv =====
// ----------------------------------------------------------------------------
// keystroke_checker
// Watches both stream ports of the boot keyboard translator, predicts the key
// events of every accepted report and compares them in order with the events
// that leave the block.
// ----------------------------------------------------------------------------
module keystroke_checker import hbkt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tlast_i,
  output int                  fail_count_o,
  output int                  events_pending_o
);

  localparam logic [UsageW-1:0] DigitFirst = 8'h1E;
  localparam logic [UsageW-1:0] DigitLast  = 8'h27;
  localparam logic [UsageW-1:0] SymFirst   = 8'h2C;
  localparam logic [UsageW-1:0] SymLast    = 8'h38;
  localparam logic [UsageW-1:0] SymHole    = 8'h32;

  localparam logic [CharW-1:0] AsciiCr  = 7'd13;
  localparam logic [CharW-1:0] AsciiBs  = 7'd8;
  localparam logic [CharW-1:0] AsciiTab = 7'd9;

  localparam logic [8*10-1:0] DigitsPlain = "1234567890";
  localparam logic [8*10-1:0] DigitsShift = "!@#$%^&*()";
  // the hole at usage 0x32 is filtered out before lookup
  localparam logic [8*13-1:0] SymsPlain   = " -=[]\\ ;'`,./";
  localparam logic [8*13-1:0] SymsShift   = " _+{}| :\"~<>?";

  typedef struct packed {
    logic [ScanW-1:0] scan;
    logic [CharW-1:0] chr;
    logic             ctrl;
    logic [ModsW-1:0] mods;
    logic             last;
  } key_event_t;

  key_event_t        expected_events[$];
  logic [UsageW-1:0] held_keys [KeySlots];
  logic              caps_on;
  int                mismatches;

  function automatic logic [CharW-1:0] usage_char(input logic [UsageW-1:0] u,
                                                  input logic upper);
    logic [7:0] c;
    int         idx;
    c = '0;
    if (u >= UsageLetterA && u <= UsageLetterZ) begin
      c = (upper ? "A" : "a") + (u - UsageLetterA);
    end else if (u >= DigitFirst && u <= DigitLast) begin
      idx = int'(u - DigitFirst);
      c   = upper ? DigitsShift[8*(9-idx) +: 8] : DigitsPlain[8*(9-idx) +: 8];
    end else if (u >= SymFirst && u <= SymLast && u != SymHole) begin
      idx = int'(u - SymFirst);
      c   = upper ? SymsShift[8*(12-idx) +: 8] : SymsPlain[8*(12-idx) +: 8];
    end
    return c[CharW-1:0];
  endfunction

  task automatic predict_report(input logic [InDataW-1:0] rpt);
    logic [7:0]        mod;
    logic [UsageW-1:0] keys [KeySlots];
    logic [UsageW-1:0] u;
    logic              shift;
    logic              fresh;
    key_event_t        ev;
    key_event_t        queued_ev;
    logic              have_ev;
    mod     = rpt[7:0];
    have_ev = 1'b0;
    for (int i = 0; i < KeySlots; i++) keys[i] = rpt[UsageW*(i+1) +: UsageW];
    if (keys[0] == UsageRollover) return;
    shift = |(mod & ModShift);
    for (int i = 0; i < KeySlots; i++) begin
      u     = keys[i];
      fresh = (u != '0);
      for (int j = 0; j < KeySlots; j++) if (held_keys[j] == u) fresh = 1'b0;
      if (fresh && u == UsageCaps) begin
        caps_on = ~caps_on;
      end else if (fresh) begin
        ev      = '0;
        ev.ctrl = |(mod & ModCtrl);
        ev.mods = {|(mod & ModGui), |(mod & ModAlt), |(mod & ModCtrl), shift};
        case (u)
          UsageEnter:  ev.chr  = AsciiCr;
          UsageBksp:   ev.chr  = AsciiBs;
          UsageTab:    ev.chr  = AsciiTab;
          UsageEscape: ev.scan = ScanEscape;
          UsageDelete: ev.scan = ScanDelete;
          UsageRight:  ev.scan = ScanRight;
          UsageLeft:   ev.scan = ScanLeft;
          UsageDown:   ev.scan = ScanDown;
          UsageUp:     ev.scan = ScanUp;
          default: begin
            ev.chr = usage_char(u, shift ^ (caps_on && u >= UsageLetterA &&
                                            u <= UsageLetterZ));
          end
        endcase
        if (ev.scan != '0 || ev.chr != '0) begin
          if (have_ev) expected_events.push_back(queued_ev);
          queued_ev = ev;
          have_ev   = 1'b1;
        end
      end
    end
    if (have_ev) begin
      queued_ev.last = 1'b1;
      expected_events.push_back(queued_ev);
    end
    for (int i = 0; i < KeySlots; i++) held_keys[i] = keys[i];
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_event_t want;
    key_event_t seen;
    if (!rst_ni) begin
      expected_events.delete();
      for (int i = 0; i < KeySlots; i++) held_keys[i] = '0;
      caps_on          = 1'b0;
      mismatches       = 0;
      fail_count_o     <= 0;
      events_pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen.scan = m_tdata_i[ScanW-1:0];
        seen.chr  = m_tdata_i[ScanW +: CharW];
        seen.ctrl = m_tdata_i[ScanW+CharW];
        seen.mods = m_tdata_i[ScanW+CharW+1 +: ModsW];
        seen.last = m_tlast_i;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual tdata %h tlast %b",
                   $time, m_tdata_i, m_tlast_i);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("scan_code", int'(want.scan), int'(seen.scan));
          check_field("char_code", int'(want.chr), int'(seen.chr));
          check_field("ctrl_held", int'(want.ctrl), int'(seen.ctrl));
          check_field("held_mods", int'(want.mods), int'(seen.mods));
          check_field("last_event", int'(want.last), int'(seen.last));
        end
      end
      if (s_tvalid_i && s_tready_i) predict_report(s_tdata_i);
      fail_count_o     <= mismatches;
      events_pending_o <= expected_events.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for hid_boot_keyboard_translator_core: directed reports for every
// key class and corner case, then random typing sequences under three idle
// and stall profiles, checked event by event by keystroke_checker.
// ----------------------------------------------------------------------------
module tb import hbkt_pkg::*;;

  localparam logic [UsageW-1:0] SymLast    = 8'h38;
  localparam logic [UsageW-1:0] UsageHigh  = 8'h3A;
  localparam logic [7:0]        ShiftLeft  = 8'h02;
  localparam logic [7:0]        ShiftRight = 8'h20;
  localparam int                PhaseItems = 82;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int                fail_count;
  int                events_pending;
  int                send_gap_pct   = 22;
  int                recv_stall_pct = 62;
  logic [UsageW-1:0] last_typed [KeySlots];

  logic [UsageW-1:0] special_keys [9] = '{UsageEnter, UsageEscape, UsageBksp, UsageTab,
                                          UsageDelete, UsageRight, UsageLeft, UsageDown,
                                          UsageUp};

  hid_boot_keyboard_translator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  keystroke_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tlast_i        (m_axis_tlast),
    .fail_count_o     (fail_count),
    .events_pending_o (events_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [InDataW-1:0] report(input logic [7:0] m,
      input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2,
      input logic [7:0] k3, input logic [7:0] k4, input logic [7:0] k5);
    return {k5, k4, k3, k2, k1, k0, m};
  endfunction

  task automatic send_report(input logic [InDataW-1:0] rpt);
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rpt;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // typing model: keys stay held, get released, new ones are pressed
  task automatic send_typing_report();
    logic [7:0]        mod;
    logic [UsageW-1:0] keys [KeySlots];
    int                r;
    int                p;
    logic [InDataW-1:0] rpt;
    r = $urandom_range(99);
    if (r < 35)      mod = '0;
    else if (r < 60) mod = $urandom_range(1) ? ShiftLeft : ShiftRight;
    else if (r < 80) mod = 8'($urandom_range(255));
    else             mod = 8'h01 << $urandom_range(7);
    for (int i = 0; i < KeySlots; i++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        keys[i] = last_typed[i];
      end else if (r < 35) begin
        keys[i] = '0;
      end else if (r < 75) begin
        p = $urandom_range(99);
        if (p < 70)      keys[i] = UsageW'($urandom_range(UsageLetterA, SymLast));
        else if (p < 85) keys[i] = special_keys[$urandom_range(8)];
        else             keys[i] = UsageW'($urandom_range(UsageHigh, 8'hFF));
      end else if (r < 82) begin
        keys[i] = UsageCaps;
      end else if (r < 88) begin
        keys[i] = last_typed[$urandom_range(KeySlots-1)];
      end else if (r < 92 && i > 0) begin
        keys[i] = keys[$urandom_range(i-1)];
      end else begin
        keys[i] = UsageW'($urandom_range(255));
      end
    end
    if ($urandom_range(99) < 5) begin
      keys[0] = UsageRollover;
    end else begin
      for (int i = 0; i < KeySlots; i++) last_typed[i] = keys[i];
    end
    rpt = {keys[5], keys[4], keys[3], keys[2], keys[1], keys[0], mod};
    send_report(rpt);
  endtask

  initial begin
    for (int i = 0; i < KeySlots; i++) last_typed[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, UsageLetterA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'hFF, UsageEnter, UsageBksp, UsageTab, UsageEscape, UsageDelete,
                       UsageRight));
    send_report(report(8'h00, UsageLeft, UsageDown, UsageUp, 8'h2C, UsageLetterZ, 8'h27));
    send_report(report(ShiftRight, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23));
    send_report(report(ShiftLeft, 8'h24, 8'h25, 8'h26, 8'h2D, 8'h2E, 8'h2F));
    send_report(report(8'h00, 8'h30, 8'h31, 8'h33, 8'h34, 8'h35, 8'h36));
    send_report(report(8'h00, 8'h37, 8'h38, 8'h32, 8'h02, 8'h03, UsageHigh));
    // caps on, then letter and symbol after it in the same report
    send_report(report(8'h00, UsageCaps, 8'h06, 8'h2D, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, UsageCaps, 8'h06, 8'h2D, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, UsageRollover, 8'h07, 8'h08, 8'hFF, 8'h80, 8'h55));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(ShiftLeft, UsageCaps, 8'h05, UsageCaps, 8'h06, 8'h1E, 8'h00));
    send_report(report(8'h00, 8'h07, 8'h07, 8'h00, 8'h07, 8'h00, 8'h00));
    send_report(report(8'hAA, 8'hFF, 8'h80, 8'hE0, 8'h53, 8'h7F, 8'h01));
    for (int b = 0; b < 8; b++) begin
      send_report(report(8'h01 << b, UsageW'(UsageLetterA + b), 8'h00, 8'h00, 8'h00,
                         8'h00, 8'h00));
    end

    repeat (PhaseItems) send_typing_report();
    send_gap_pct   = 62;
    recv_stall_pct = 22;
    repeat (PhaseItems) send_typing_report();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (PhaseItems) send_typing_report();
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (events_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && events_pending == 0) begin
      $display("hid_boot_keyboard_translator_core verification clean");
    end else begin
      $display("hid_boot_keyboard_translator_core verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("hid_boot_keyboard_translator_core verification failed");
    $finish;
  end

endmodule
